@@ design/sis_pkg.sv @@
// ----------------------------------------------------------------------------
// Sorted insertion stack package
// Shared types, codes and sizing constants for the sorted insertion stack.
// ----------------------------------------------------------------------------
package sis_pkg;

	localparam int DEPTH_DEF = 32;
	localparam int DATA_W    = 8;
	localparam int KIND_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int OCC_W     = 6;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POP    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DUMP   = 2'd2;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [DATA_W-1:0] value;
	} req_t;

	typedef struct packed {
		logic [DATA_W-1:0]   data;
		logic [STATUS_W-1:0] status;
		logic [OCC_W-1:0]    occupancy;
		logic                last;
	} rsp_t;

	typedef enum logic [1:0] {
		OP_HOLD   = 2'd0,
		OP_INSERT = 2'd1,
		OP_POP    = 2'd2,
		OP_ROTATE = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t          op;
		logic [DATA_W-1:0] value;
	} cell_cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DUMP = 2'b10
	} state_t;

endpackage

@@ design/sorted_insertion_stack_top.sv @@
// ----------------------------------------------------------------------------
// Sorted insertion stack
// Bounded stack of bytes kept in ascending order from bottom to top.
// ----------------------------------------------------------------------------
// The req channel carries one transaction per operation: sorted insert, pop
// of the top (greatest) entry, or dump of all entries from top to bottom.
// The rsp channel carries results. Insert and pop give one result each; a
// dump gives one result per held entry with last set on the bottom entry,
// or a single empty result. An unused kind gives no result.
// Results appear on rsp in the cycle after the transaction is accepted.
// Insert and pop complete when accepted, so one transaction per cycle is
// accepted while rsp drains. A dump of N entries occupies the block until
// it has given all N entries, one entry per cycle while rsp drains, because
// the cell chain rotates by one slot per result to bring each entry to its head.
// The result register holds one result; while the receiver stalls, req_ready
// stays low and the chain holds.
// Reset clears the entry count and the result valid flag; stored bytes are
// not cleared and are never read before they are written.
// ----------------------------------------------------------------------------
module sorted_insertion_stack_top #(
	parameter int DEPTH = sis_pkg::DEPTH_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  sis_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output sis_pkg::rsp_t rsp
);

	localparam int CNT_W = $clog2(DEPTH+1);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

	sis_pkg::state_t             state_q;
	sis_pkg::state_t             state_d;
	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            count_d;
	logic [CNT_W-1:0]            remain_q;
	logic [CNT_W-1:0]            remain_d;
	logic                        rsp_valid_q;
	sis_pkg::rsp_t               rsp_q;
	sis_pkg::rsp_t               rsp_d;
	logic                        emit;
	logic                        out_free;
	logic                        accept;
	sis_pkg::cell_cmd_t          cmd;
	logic [sis_pkg::DATA_W-1:0]  head;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == sis_pkg::ST_IDLE) && out_free;
	assign accept    = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		remain_d  = remain_q;
		emit      = 1'b0;
		cmd.op    = sis_pkg::OP_HOLD;
		cmd.value = req.value;
		rsp_d     = '{data: '0, status: sis_pkg::STATUS_OK,
			occupancy: sis_pkg::OCC_W'(count_q), last: 1'b1};
		case (state_q)
			sis_pkg::ST_IDLE: begin
				if (accept) begin
					case (req.kind)
						sis_pkg::KIND_INSERT: begin
							emit = 1'b1;
							if (count_q == DEPTH_C) begin
								rsp_d.status = sis_pkg::STATUS_FULL;
							end else begin
								cmd.op          = sis_pkg::OP_INSERT;
								count_d         = count_q + ONE_C;
								rsp_d.occupancy = sis_pkg::OCC_W'(count_d);
							end
						end
						sis_pkg::KIND_POP: begin
							emit = 1'b1;
							if (count_q == '0) begin
								rsp_d.status = sis_pkg::STATUS_EMPTY;
							end else begin
								cmd.op          = sis_pkg::OP_POP;
								count_d         = count_q - ONE_C;
								rsp_d.data      = head;
								rsp_d.occupancy = sis_pkg::OCC_W'(count_d);
							end
						end
						sis_pkg::KIND_DUMP: begin
							emit = 1'b1;
							if (count_q == '0) begin
								rsp_d.status = sis_pkg::STATUS_EMPTY;
							end else begin
								cmd.op     = sis_pkg::OP_ROTATE;
								rsp_d.data = head;
								rsp_d.last = (count_q == ONE_C);
								remain_d   = count_q - ONE_C;
								if (count_q != ONE_C) begin
									state_d = sis_pkg::ST_DUMP;
								end
							end
						end
						default: begin
							emit = 1'b0;
						end
					endcase
				end
			end
			sis_pkg::ST_DUMP: begin
				if (out_free) begin
					emit       = 1'b1;
					cmd.op     = sis_pkg::OP_ROTATE;
					rsp_d.data = head;
					rsp_d.last = (remain_q == ONE_C);
					remain_d   = remain_q - ONE_C;
					if (remain_q == ONE_C) begin
						state_d = sis_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = sis_pkg::ST_IDLE;
			end
		endcase
	end

	sis_chain #(
		.DEPTH(DEPTH)
	) u_chain (
		.clk  (clk),
		.cmd  (cmd),
		.count(count_q),
		.head (head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= sis_pkg::ST_IDLE;
			count_q     <= '0;
			remain_q    <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			count_q  <= count_d;
			remain_q <= remain_d;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q <= rsp_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= DEPTH_C)
		else $error("Entry count exceeds the stack depth.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req.kind == sis_pkg::KIND_INSERT && count_q != DEPTH_C)
		|=> count_q == $past(count_q) + ONE_C)
		else $error("Accepted insert did not grow the stack.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sis_pkg::ST_DUMP) |-> (!req_ready && remain_q != '0 && remain_q < count_q))
		else $error("Dump bookkeeping is inconsistent.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sis_pkg::ST_DUMP) |=> $stable(count_q))
		else $error("Entry count changed during a dump.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == sis_pkg::ST_DUMP && out_free && remain_q == ONE_C)
		|=> (state_q == sis_pkg::ST_IDLE && rsp_valid_q && rsp_q.last))
		else $error("Dump did not end with a last result.");

endmodule

@@ design/sis_cell.sv @@
// ----------------------------------------------------------------------------
// Sorted insertion stack cell
// One slot of the chain. Slot 0 is the top of the stack; values descend
// toward higher slots.
// ----------------------------------------------------------------------------
module sis_cell #(
	parameter int DEPTH = sis_pkg::DEPTH_DEF,
	parameter int IDX   = 0
) (
	input  logic                             clk,
	input  sis_pkg::cell_cmd_t               cmd,
	input  logic [$clog2(DEPTH+1)-1:0]       count,
	input  logic [sis_pkg::DATA_W-1:0]       left_val,
	input  logic                             left_gt,
	input  logic [sis_pkg::DATA_W-1:0]       right_val,
	input  logic [sis_pkg::DATA_W-1:0]       head_val,
	output logic [sis_pkg::DATA_W-1:0]       val,
	output logic                             gt
);

	localparam int CNT_W = $clog2(DEPTH+1);
	localparam logic [CNT_W-1:0] IDX_C  = CNT_W'(IDX);
	localparam logic [CNT_W-1:0] IDX_P1 = CNT_W'(IDX + 1);

	logic [sis_pkg::DATA_W-1:0] val_q;
	logic [sis_pkg::DATA_W-1:0] val_d;

	assign gt  = (IDX_C < count) && (val_q > cmd.value);
	assign val = val_q;

	always_comb begin
		case (cmd.op)
			sis_pkg::OP_HOLD: begin
				val_d = val_q;
			end
			sis_pkg::OP_INSERT: begin
				if (gt) begin
					val_d = val_q;
				end else if (left_gt) begin
					val_d = cmd.value;
				end else begin
					val_d = left_val;
				end
			end
			sis_pkg::OP_POP: begin
				val_d = right_val;
			end
			sis_pkg::OP_ROTATE: begin
				val_d = (count == IDX_P1) ? head_val : right_val;
			end
			default: begin
				val_d = val_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		val_q <= val_d;
	end

endmodule

@@ design/sis_chain.sv @@
// ----------------------------------------------------------------------------
// Sorted insertion stack chain
// Row of cells that insert, pop, rotate or hold the stored values, all cells together.
// ----------------------------------------------------------------------------
module sis_chain #(
	parameter int DEPTH = sis_pkg::DEPTH_DEF
) (
	input  logic                             clk,
	input  sis_pkg::cell_cmd_t               cmd,
	input  logic [$clog2(DEPTH+1)-1:0]       count,
	output logic [sis_pkg::DATA_W-1:0]       head
);

	logic [sis_pkg::DATA_W-1:0] vals [DEPTH];
	logic                       gts  [DEPTH];

	assign head = vals[0];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [sis_pkg::DATA_W-1:0] lv;
		logic                       lg;
		logic [sis_pkg::DATA_W-1:0] rv;

		if (i == 0) begin : g_first
			assign lv = cmd.value;
			assign lg = 1'b1;
		end else begin : g_inner
			assign lv = vals[i-1];
			assign lg = gts[i-1];
		end

		if (i == DEPTH - 1) begin : g_last
			assign rv = vals[i];
		end else begin : g_body
			assign rv = vals[i+1];
		end

		sis_cell #(
			.DEPTH(DEPTH),
			.IDX  (i)
		) u_cell (
			.clk      (clk),
			.cmd      (cmd),
			.count    (count),
			.left_val (lv),
			.left_gt  (lg),
			.right_val(rv),
			.head_val (vals[0]),
			.val      (vals[i]),
			.gt       (gts[i])
		);
	end

endmodule
